[src/mfjq_pkg.sv]
// Shared types, codes and default sizes for the multilevel feedback job queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mfjq_pkg;

  // Default sizing, taken as the defaults of the top level parameters
  localparam int unsigned QUEUE_DEPTH_DEF = 128;
  localparam int unsigned LEVELS_DEF      = 4;
  localparam int unsigned MAX_CPUS_DEF    = 8;
  localparam int unsigned JOBS_DEF        = 256;

  // Fixed field widths
  localparam int unsigned JOB_W    = 8;
  localparam int unsigned PRIO_W   = 3;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CPUS_W   = 4;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned CPU_CAP  = 8;

  // Register port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [0:0]  REG_CPUS = 1'b0;
  localparam logic [CPUS_W-1:0] CPUS_RST = 4'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_GIVEBACK = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED     = 3'd0,
    ST_FULL       = 3'd1,
    ST_DISPATCHED = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_RETIRED    = 3'd4
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic enqueue;
    logic clr_started;
    logic emit_single;
    logic start_disp;
    logic pop;
    logic rd_started;
    logic emit_disp;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic fin;
    logic lvl_empty;
    logic out_free;
    logic last_job;
  } dp_stat_t;

endpackage

[src/mfjq_regs.sv]
// Register block: holds the cpus register behind the APB-style port.
// Depends on mfjq_pkg.
`timescale 1ns / 1ps

module mfjq_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfjq_pkg::APB_AW-1:0]   paddr,
  input  logic [mfjq_pkg::APB_DW-1:0]   pwdata,
  output logic [mfjq_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [mfjq_pkg::CPUS_W-1:0]   cpus_o
);
  import mfjq_pkg::*;

  logic [CPUS_W-1:0] cpus_q, cpus_d;
  logic              reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_CPUS);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  always_comb begin
    cpus_d = cpus_q;
    if (wr_en) begin
      cpus_d = pwdata[CPUS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpus_q <= CPUS_RST;
    end else begin
      cpus_q <= cpus_d;
    end
  end

  assign prdata = reg_sel ? {{(APB_DW-CPUS_W){1'b0}}, cpus_q} : '0;
  assign cpus_o = cpus_q;

endmodule

[src/mfjq_ctrl.sv]
// Sequencer for the job queue: decodes the latched item and steps the datapath
// through enqueue, empty report or the per-job dispatch loop. Depends on mfjq_pkg.
`timescale 1ns / 1ps

module mfjq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mfjq_pkg::dp_stat_t stat_i,
  output mfjq_pkg::dp_cmd_t  ctl_o
);
  import mfjq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_LOOKUP,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.cmd)
          CMD_SUBMIT: begin
            if (stat_i.out_free) begin
              ctl_o.enqueue     = 1'b1;
              ctl_o.clr_started = 1'b1;
              ctl_o.emit_single = 1'b1;
              state_d           = S_IDLE;
            end
          end
          CMD_GIVEBACK: begin
            if (stat_i.out_free) begin
              ctl_o.enqueue     = !stat_i.fin;
              ctl_o.emit_single = 1'b1;
              state_d           = S_IDLE;
            end
          end
          CMD_DISPATCH: begin
            if (stat_i.lvl_empty) begin
              if (stat_i.out_free) begin
                ctl_o.emit_single = 1'b1;
                state_d           = S_IDLE;
              end
            end else begin
              ctl_o.start_disp = 1'b1;
              state_d          = S_POP;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_POP: begin
        ctl_o.pop = 1'b1;
        state_d   = S_LOOKUP;
      end
      S_LOOKUP: begin
        ctl_o.rd_started = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          ctl_o.emit_disp = 1'b1;
          state_d         = stat_i.last_job ? S_IDLE : S_POP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // one item at a time: an accepted beat closes the input until it is done
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

endmodule

[src/mfjq_dp.sv]
// Datapath: latched item, per-level ring pointers and counts, ring and started-bit
// memories, dispatch countdown and the output register. Depends on mfjq_pkg.
`timescale 1ns / 1ps

module mfjq_dp #(
  parameter int unsigned QUEUE_DEPTH = mfjq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned LEVELS      = mfjq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_CPUS    = mfjq_pkg::MAX_CPUS_DEF,
  parameter int unsigned JOBS        = mfjq_pkg::JOBS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfjq_pkg::dp_cmd_t             ctl_i,
  output mfjq_pkg::dp_stat_t            stat_o,
  input  logic [mfjq_pkg::CPUS_W-1:0]   cpus_i,
  input  mfjq_pkg::cmd_e                in_cmd_i,
  input  logic [mfjq_pkg::JOB_W-1:0]    in_job_i,
  input  logic [mfjq_pkg::PRIO_W-1:0]   in_prio_i,
  input  logic                          in_fin_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output mfjq_pkg::status_e             out_status_o,
  output logic [mfjq_pkg::JOB_W-1:0]    out_job_o,
  output logic [mfjq_pkg::PRIO_W-1:0]   out_level_o,
  output logic                          out_first_o,
  output logic                          out_last_o
);
  import mfjq_pkg::*;

  localparam int unsigned PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LIDX_W     = $clog2(LEVELS);
  localparam int unsigned RING_DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
  localparam int unsigned SDEPTH     = (JOBS < 256) ? JOBS : 256;
  localparam int unsigned SIDX_W     = $clog2(SDEPTH);

  // job number modulo JOBS; quotient of an 8-bit job by JOBS >= 16 fits 4 bits
  function automatic logic [SIDX_W-1:0] job_slot(input logic [JOB_W-1:0] job);
    logic [JOB_W-1:0] r;
    r = job;
    for (int k = 3; k >= 0; k--) begin
      if (32'(r) >= (JOBS << k)) begin
        r = r - JOB_W'(JOBS << k);
      end
    end
    return r[SIDX_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // latched item
  cmd_e              cmd_q;
  logic [JOB_W-1:0]  job_q;
  logic [LIDX_W-1:0] lvl_q;
  logic              fin_q;
  logic [LIDX_W-1:0] lvl_in;

  // per-level queue state
  logic [PTR_W-1:0]  head_q [LEVELS];
  logic [PTR_W-1:0]  tail_q [LEVELS];
  logic [CNT_W-1:0]  occ_q  [LEVELS];
  logic [PTR_W-1:0]  head_cur, tail_cur;
  logic [CNT_W-1:0]  occ_cur;
  logic              full, empty;

  // memories
  logic [JOB_W-1:0]   ring_mem [RING_DEPTH];
  logic [JOB_W-1:0]   ring_rd_q;
  logic [RING_AW-1:0] ring_waddr, ring_raddr;
  logic               ring_we;
  logic               started_mem [SDEPTH];
  logic               started_rd_q;
  logic [SIDX_W-1:0]  sidx_sub, sidx_disp, st_waddr;
  logic               st_we;

  // dispatch
  logic [CPUS_W-1:0] ncpu, n_disp, rem_q;

  // output register
  logic              out_valid_q;
  status_e           out_status_q, single_status;
  logic [JOB_W-1:0]  out_job_q, single_job;
  logic [PRIO_W-1:0] out_lvl_q, level_out;
  logic              out_first_q, out_last_q;
  logic              out_free;

  // level clamp; a give back that is not finished drops one level, floor 1
  always_comb begin
    int unsigned lv;
    if (in_prio_i == '0) begin
      lv = 0;
    end else if (32'(in_prio_i) > LEVELS) begin
      lv = LEVELS - 1;
    end else begin
      lv = 32'(in_prio_i) - 1;
    end
    if (in_cmd_i == CMD_GIVEBACK && !in_fin_i && lv > 0) begin
      lv = lv - 1;
    end
    lvl_in = LIDX_W'(lv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_NONE;
      job_q <= '0;
      lvl_q <= '0;
      fin_q <= 1'b0;
    end else if (ctl_i.load) begin
      cmd_q <= in_cmd_i;
      job_q <= in_job_i;
      lvl_q <= lvl_in;
      fin_q <= in_fin_i;
    end
  end

  assign head_cur  = head_q[lvl_q];
  assign tail_cur  = tail_q[lvl_q];
  assign occ_cur   = occ_q[lvl_q];
  assign full      = (occ_cur == CNT_W'(QUEUE_DEPTH));
  assign empty     = (occ_cur == '0);
  assign level_out = PRIO_W'(lvl_q) + PRIO_W'(1);

  // jobs per dispatch: cpus clamped, then limited by what the level holds
  always_comb begin
    ncpu = cpus_i;
    if (ncpu == '0) begin
      ncpu = CPUS_W'(1);
    end
    if (32'(ncpu) > MAX_CPUS) begin
      ncpu = CPUS_W'(MAX_CPUS);
    end
    if (32'(ncpu) > CPU_CAP) begin
      ncpu = CPUS_W'(CPU_CAP);
    end
    n_disp = ncpu;
    if (32'(occ_cur) < 32'(ncpu)) begin
      n_disp = CPUS_W'(occ_cur);
    end
  end

  // ring memory: one write port (enqueue), one registered read (pop)
  assign ring_we    = ctl_i.enqueue && !full;
  assign ring_waddr = RING_AW'(lvl_q) * RING_AW'(QUEUE_DEPTH) + RING_AW'(tail_cur);
  assign ring_raddr = RING_AW'(lvl_q) * RING_AW'(QUEUE_DEPTH) + RING_AW'(head_cur);

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= job_q;
    end
    if (ctl_i.pop) begin
      ring_rd_q <= ring_mem[ring_raddr];
    end
  end

  // started bits: cleared on submit, set on dispatch
  assign sidx_sub  = job_slot(job_q);
  assign sidx_disp = job_slot(ring_rd_q);
  assign st_we     = (ctl_i.clr_started && !full) || ctl_i.emit_disp;
  assign st_waddr  = ctl_i.emit_disp ? sidx_disp : sidx_sub;

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      started_mem[st_waddr] <= ctl_i.emit_disp;
    end
    if (ctl_i.rd_started) begin
      started_rd_q <= started_mem[sidx_disp];
    end
  end

  always_comb begin
    single_status = ST_QUEUED;
    single_job    = job_q;
    case (cmd_q)
      CMD_SUBMIT:   single_status = full ? ST_FULL : ST_QUEUED;
      CMD_GIVEBACK: single_status = fin_q ? ST_RETIRED : (full ? ST_FULL : ST_QUEUED);
      CMD_DISPATCH: begin
        single_status = ST_EMPTY;
        single_job    = '0;
      end
      default: single_status = ST_QUEUED;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ring_we) begin
        tail_q[lvl_q] <= ptr_next(tail_cur);
        occ_q[lvl_q]  <= occ_cur + CNT_W'(1);
      end
      if (ctl_i.pop) begin
        head_q[lvl_q] <= ptr_next(head_cur);
        occ_q[lvl_q]  <= occ_cur - CNT_W'(1);
      end
      if (ctl_i.start_disp) begin
        rem_q <= n_disp;
      end else if (ctl_i.emit_disp) begin
        rem_q <= rem_q - CPUS_W'(1);
      end
      if (ctl_i.emit_single || ctl_i.emit_disp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_single) begin
      out_status_q <= single_status;
      out_job_q    <= single_job;
      out_lvl_q    <= level_out;
      out_first_q  <= 1'b0;
      out_last_q   <= 1'b1;
    end else if (ctl_i.emit_disp) begin
      out_status_q <= ST_DISPATCHED;
      out_job_q    <= ring_rd_q;
      out_lvl_q    <= level_out;
      out_first_q  <= !started_rd_q;
      out_last_q   <= (rem_q == CPUS_W'(1));
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.fin       = fin_q;
  assign stat_o.lvl_empty = empty;
  assign stat_o.out_free  = out_free;
  assign stat_o.last_job  = (rem_q == CPUS_W'(1));

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_job_o    = out_job_q;
  assign out_level_o  = out_lvl_q;
  assign out_first_o  = out_first_q;
  assign out_last_o   = out_last_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_cur) <= QUEUE_DEPTH)
    else $error("level count above ring depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> !empty)
    else $error("pop from empty level");

  a_emit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit_disp |-> rem_q != '0)
    else $error("dispatch beat without remaining jobs");

endmodule

[src/multilevel_feedback_job_queue_core.sv]
// Top level of the multilevel feedback job queue.
// Depends on mfjq_pkg, mfjq_regs, mfjq_ctrl and mfjq_dp.
`timescale 1ns / 1ps

// Usage:
//  Input stream (s_axis): one beat per command. tuser carries the command
//  (submit, dispatch, give back); tdata carries job, priority/level, finished.
//  Output stream (m_axis): one beat per result. tuser is the status, tdata
//  carries job, level and first-run flag, tlast marks the final beat of a
//  command. Submit and give back give one beat; dispatch gives one beat per
//  popped job (up to cpus) or one level-empty beat; an unknown command none.
//  Timing: the block takes one command at a time. Submit, give back and an
//  empty dispatch are latched, then their result is registered. A dispatch
//  steps each job through a ring read, then a started-bit read. The output
//  register decouples the sides: the next command is accepted while a result
//  waits, and a stalled m_axis holds the sequencer in place. Reset empties all
//  levels and sets cpus to 1; no clearing pass is needed. The user must write
//  cpus at byte address 0 of the APB-style port only while idle (unenforced).

module multilevel_feedback_job_queue_core #(
  parameter int unsigned QUEUE_DEPTH = mfjq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned LEVELS      = mfjq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_CPUS    = mfjq_pkg::MAX_CPUS_DEF,
  parameter int unsigned JOBS        = mfjq_pkg::JOBS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] job_id, [10:8] priority_req, [11] finished, [15:12] zero
  input  logic [mfjq_pkg::DATA_W-1:0]   s_axis_tdata,
  // [1:0] cmd
  input  logic [mfjq_pkg::CMD_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] job_id_out, [10:8] level_out, [11] first_run, [15:12] zero
  output logic [mfjq_pkg::DATA_W-1:0]   m_axis_tdata,
  // [2:0] status
  output logic [mfjq_pkg::STATUS_W-1:0] m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfjq_pkg::APB_AW-1:0]   paddr,
  input  logic [mfjq_pkg::APB_DW-1:0]   pwdata,
  output logic [mfjq_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mfjq_pkg::*;

  logic [CPUS_W-1:0] cpus;
  dp_cmd_t           dp_cmd;
  dp_stat_t          dp_stat;
  status_e           out_status;
  logic [JOB_W-1:0]  out_job;
  logic [PRIO_W-1:0] out_level;
  logic              out_first;

  mfjq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cpus_o  (cpus)
  );

  mfjq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .ctl_o      (dp_cmd)
  );

  mfjq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEVELS      (LEVELS),
    .MAX_CPUS    (MAX_CPUS),
    .JOBS        (JOBS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (dp_cmd),
    .stat_o       (dp_stat),
    .cpus_i       (cpus),
    .in_cmd_i     (cmd_e'(s_axis_tuser)),
    .in_job_i     (s_axis_tdata[7:0]),
    .in_prio_i    (s_axis_tdata[10:8]),
    .in_fin_i     (s_axis_tdata[11]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_job_o    (out_job),
    .out_level_o  (out_level),
    .out_first_o  (out_first),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_first, out_level, out_job};
  assign m_axis_tuser = out_status;

endmodule

[bench/multilevel_feedback_job_queue_core_tb.sv]
// Self-checking bench for multilevel_feedback_job_queue_core: a directed pass, then random
// phases under several cpus settings, with an in-bench mirror of the four job rings.
// Depends on mfjq_pkg and the core RTL only.
`timescale 1ns / 1ps

module multilevel_feedback_job_queue_core_tb;
  import mfjq_pkg::*;

  localparam int unsigned QDEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned NLEVELS      = LEVELS_DEF;
  localparam int unsigned NCPUS        = MAX_CPUS_DEF;
  localparam int unsigned NJOBS        = JOBS_DEF;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 800_000;
  localparam int unsigned PHASE_ITEMS  = 62;
  localparam logic [APB_AW-1:0] CPUS_ADDR = APB_AW'(4 * REG_CPUS);

  typedef enum {RDY_OPEN, RDY_RANDOM, RDY_PERIODIC, RDY_HOLD} stall_mode_e;

  typedef struct {
    status_e           status;
    logic [JOB_W-1:0]  job;
    logic [PRIO_W-1:0] level;
    logic              first_run;
    logic              last;
  } sched_beat_t;

  // Mirror of the rings, started bits and cpus; holds the beats still due.
  class job_queue_mirror;
    logic [JOB_W-1:0]  ring [NLEVELS][QDEPTH];
    int unsigned       head [NLEVELS];
    int unsigned       tail [NLEVELS];
    int unsigned       fill [NLEVELS];
    bit                started [NJOBS];
    bit                submitted [NJOBS];
    logic [JOB_W-1:0]  known_ids [$];
    logic [CPUS_W-1:0] cpus;
    sched_beat_t       due_beats [$];
    int unsigned       errors;

    function new();
      cpus   = CPUS_RST;
      errors = 0;
    endfunction

    function int unsigned clamp_level(logic [PRIO_W-1:0] p);
      if (p == 0) return 1;
      if (p > NLEVELS) return NLEVELS;
      return p;
    endfunction

    function bit push_job(int unsigned lvl, logic [JOB_W-1:0] job);
      if (fill[lvl-1] >= QDEPTH) return 1'b0;
      ring[lvl-1][tail[lvl-1]] = job;
      tail[lvl-1] = (tail[lvl-1] + 1) % QDEPTH;
      fill[lvl-1]++;
      return 1'b1;
    endfunction

    function void add_beat(status_e st, logic [JOB_W-1:0] job, int unsigned lvl,
                           bit first, bit last);
      sched_beat_t b;
      b.status    = st;
      b.job       = job;
      b.level     = PRIO_W'(lvl);
      b.first_run = first;
      b.last      = last;
      due_beats.push_back(b);
    endfunction

    function void accept_cmd(cmd_e cmd, logic [JOB_W-1:0] job, logic [PRIO_W-1:0] prio,
                             logic fin);
      int unsigned      lvl;
      int unsigned      n;
      int unsigned      i;
      logic [JOB_W-1:0] j;
      lvl = clamp_level(prio);
      case (cmd)
        CMD_SUBMIT: begin
          if (push_job(lvl, job)) begin
            started[job] = 1'b0;
            if (!submitted[job]) begin
              submitted[job] = 1'b1;
              known_ids.push_back(job);
            end
            add_beat(ST_QUEUED, job, lvl, 1'b0, 1'b1);
          end else begin
            add_beat(ST_FULL, job, lvl, 1'b0, 1'b1);
          end
        end
        CMD_DISPATCH: begin
          n = (cpus == 0) ? 1 : (cpus > NCPUS) ? NCPUS : cpus;
          if (fill[lvl-1] == 0) begin
            add_beat(ST_EMPTY, '0, lvl, 1'b0, 1'b1);
          end else begin
            if (n > fill[lvl-1]) n = fill[lvl-1];
            for (i = 0; i < n; i++) begin
              j = ring[lvl-1][head[lvl-1]];
              head[lvl-1] = (head[lvl-1] + 1) % QDEPTH;
              fill[lvl-1]--;
              add_beat(ST_DISPATCHED, j, lvl, !started[j], i + 1 == n);
              started[j] = 1'b1;
            end
          end
        end
        CMD_GIVEBACK: begin
          if (fin) begin
            add_beat(ST_RETIRED, job, lvl, 1'b0, 1'b1);
          end else begin
            // demote one level, never below 1
            lvl = (lvl > 1) ? lvl - 1 : 1;
            if (push_job(lvl, job)) begin
              add_beat(ST_QUEUED, job, lvl, 1'b0, 1'b1);
            end else begin
              add_beat(ST_FULL, job, lvl, 1'b0, 1'b1);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [STATUS_W-1:0] st, logic [JOB_W-1:0] job,
                             logic [PRIO_W-1:0] lvl, logic first, logic last);
      sched_beat_t b;
      if (due_beats.size() == 0) begin
        $error("unexpected beat: status %0d job_id_out %0d", st, job);
        errors++;
        return;
      end
      b = due_beats.pop_front();
      if (st !== b.status) begin
        $error("status: expected %0d, actual %0d", b.status, st);
        errors++;
      end
      if (job !== b.job) begin
        $error("job_id_out: expected %0d, actual %0d", b.job, job);
        errors++;
      end
      if (lvl !== b.level) begin
        $error("level_out: expected %0d, actual %0d", b.level, lvl);
        errors++;
      end
      if (first !== b.first_run) begin
        $error("first_run: expected %0d, actual %0d", b.first_run, first);
        errors++;
      end
      if (last !== b.last) begin
        $error("last: expected %0d, actual %0d", b.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata;
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  job_queue_mirror mirror;
  int unsigned     burst_left;
  int unsigned     cycle_cnt = 0;

  multilevel_feedback_job_queue_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("multilevel_feedback_job_queue_core regression: fail");
      $finish;
    end
  end

  // Sender: bursts of random length, random gaps between them.
  task automatic send_cmd(cmd_e cmd, logic [JOB_W-1:0] job, logic [PRIO_W-1:0] prio,
                          logic fin);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {4'b0000, fin, prio, job};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror.accept_cmd(cmd, job, prio, fin);
  endtask

  // Drop valid, wait for every due beat, then let a trailing dispatch finish.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (mirror.due_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic read_cpus();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = CPUS_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[CPUS_W-1:0] !== mirror.cpus) begin
      $error("cpus: expected %0d, actual %0d", mirror.cpus, prdata[CPUS_W-1:0]);
      mirror.errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic program_cpus(logic [CPUS_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CPUS_ADDR;
    // upper bits are don't-care for the 4-bit register
    pwdata  = ($urandom_range(0, 1) != 0) ? APB_DW'($urandom) : '0;
    pwdata[CPUS_W-1:0] = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    mirror.cpus = value;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    read_cpus();
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio();
    if ($urandom_range(0, 6) != 0) return PRIO_W'($urandom_range(1, NLEVELS));
    return PRIO_W'($urandom_range(0, 7));
  endfunction

  // Give back only jobs whose started bit a submit has written.
  function automatic logic [JOB_W-1:0] pick_known();
    return mirror.known_ids[$urandom_range(0, mirror.known_ids.size() - 1)];
  endfunction

  task automatic send_random_cmd();
    int unsigned       r;
    int unsigned       lvl;
    logic [JOB_W-1:0]  job;
    logic [PRIO_W-1:0] prio;
    logic              fin;
    r    = $urandom_range(0, 99);
    job  = JOB_W'($urandom);
    prio = pick_prio();
    fin  = 1'($urandom);
    if (r < 36) begin
      send_cmd(CMD_SUBMIT, job, prio, fin);
    end else if (r < 66) begin
      // mostly serve the highest busy level, as a controller would
      if ($urandom_range(0, 9) < 7) begin
        for (lvl = NLEVELS; lvl >= 1; lvl--) begin
          if (mirror.fill[lvl-1] != 0) break;
        end
        if (lvl != 0) prio = PRIO_W'(lvl);
      end
      send_cmd(CMD_DISPATCH, job, prio, fin);
    end else if (r < 95) begin
      if (mirror.known_ids.size() == 0) fin = 1'b1;
      if (!fin) job = pick_known();
      send_cmd(CMD_GIVEBACK, job, prio, fin);
    end else begin
      send_cmd(CMD_NONE, job, prio, fin);
    end
  endtask

  // Receiver: stall pattern switches at random among open, random, periodic and hold modes.
  initial begin
    stall_mode_e mode;
    int unsigned left;
    mode = RDY_OPEN;
    left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        mirror.check_beat(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8],
                          m_axis_tdata[11], m_axis_tlast);
      end
      @(negedge clk_i);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = (mode == RDY_HOLD) ? $urandom_range(4, 24) : $urandom_range(10, 60);
      end
      left--;
      case (mode)
        RDY_OPEN:     m_axis_tready = 1'b1;
        RDY_RANDOM:   m_axis_tready = ($urandom_range(0, 2) != 0);
        RDY_PERIODIC: m_axis_tready = (left % 3 == 0);
        default:      m_axis_tready = (left == 0);
      endcase
    end
  end

  initial begin
    logic [CPUS_W-1:0] cpus_plan [6];
    int unsigned       ph;
    int unsigned       k;
    int unsigned       tgt;
    int unsigned       full_hits;
    mirror        = new();
    burst_left    = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_SUBMIT;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    read_cpus();

    // directed, cpus at its reset value of 1
    send_cmd(CMD_DISPATCH, 8'hFF, 3'd2, 1'b1);   // empty level
    send_cmd(CMD_SUBMIT,   8'h00, 3'd0, 1'b0);   // level 0 clamps to 1
    send_cmd(CMD_SUBMIT,   8'hFF, 3'd7, 1'b1);   // level 7 clamps to 4
    send_cmd(CMD_SUBMIT,   8'hA5, 3'd4, 1'b0);
    send_cmd(CMD_SUBMIT,   8'h5A, 3'd3, 1'b0);
    send_cmd(CMD_SUBMIT,   8'h3C, 3'd2, 1'b1);
    send_cmd(CMD_DISPATCH, 8'h00, 3'd7, 1'b0);
    send_cmd(CMD_GIVEBACK, 8'hFF, 3'd4, 1'b0);   // demoted to 3
    send_cmd(CMD_GIVEBACK, 8'hA5, 3'd4, 1'b1);   // retired
    send_cmd(CMD_NONE,     8'h5A, 3'd5, 1'b1);   // ignored
    send_cmd(CMD_GIVEBACK, 8'h00, 3'd0, 1'b0);   // stays at level 1
    send_cmd(CMD_GIVEBACK, 8'h3C, 3'd1, 1'b0);
    settle();
    program_cpus(4'd8);
    send_cmd(CMD_DISPATCH, 8'h00, 3'd3, 1'b0);   // one fresh, one resumed
    send_cmd(CMD_DISPATCH, 8'hFF, 3'd1, 1'b1);   // same job twice in a ring
    send_cmd(CMD_DISPATCH, 8'h00, 3'd4, 1'b0);
    send_cmd(CMD_DISPATCH, 8'h00, 3'd6, 1'b0);
    send_cmd(CMD_DISPATCH, 8'h00, 3'd0, 1'b0);
    send_cmd(CMD_SUBMIT,   8'hFF, 3'd5, 1'b0);   // resubmit clears started bit
    send_cmd(CMD_GIVEBACK, 8'h80, 3'd6, 1'b1);
    send_cmd(CMD_DISPATCH, 8'h00, 3'd4, 1'b0);

    cpus_plan = '{4'd15, 4'd0, 4'd8, 4'd1, 4'd3, CPUS_W'($urandom)};
    for (ph = 0; ph < 6; ph++) begin
      settle();
      program_cpus(cpus_plan[ph]);
      if (ph == 0) begin
        // fill one ring past its depth, by submits and demotions into it
        tgt = $urandom_range(1, NLEVELS - 1);
        full_hits = 0;
        while (full_hits < 12) begin
          if (mirror.fill[tgt-1] == QDEPTH) full_hits++;
          if ($urandom_range(0, 4) != 0 || mirror.known_ids.size() == 0) begin
            send_cmd(CMD_SUBMIT, JOB_W'($urandom), PRIO_W'(tgt), 1'($urandom));
          end else begin
            send_cmd(CMD_GIVEBACK, pick_known(), PRIO_W'(tgt + 1), 1'b0);
          end
        end
      end
      for (k = 0; k < PHASE_ITEMS; k++) send_random_cmd();
    end

    settle();
    if (mirror.errors == 0) begin
      $display("multilevel_feedback_job_queue_core regression: pass");
    end else begin
      $display("multilevel_feedback_job_queue_core regression: fail");
    end
    $finish;
  end

endmodule
